[design/obf_pkg.sv]
// Shared types and constants for the outline Bezier flattener.
// Used by outline_bezier_flattener; depends on nothing else.
package obf_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int MAX_SEGMENTS = 64;
   localparam int SEG_WIDTH    = 7;
   localparam int T_WIDTH      = 17;              // Q0.16 plus the t = 1 code
   localparam int WGT_WIDTH    = 49;              // Q0.48 weights up to 2^48
   localparam int SQ_WIDTH     = 33;              // u*u, u*t, t*t
   localparam int MA_WIDTH     = 34;              // multiplier operand a, signed
   localparam int MB_WIDTH     = 25;              // multiplier operand b, unsigned
   localparam int PROD_WIDTH   = MA_WIDTH + MB_WIDTH + 1;
   localparam int ACC_WIDTH    = 82;
   localparam int WLO_WIDTH    = 25;              // low slice of a weight
   localparam logic [T_WIDTH-1:0] T_ONE = 17'h10000;
   localparam logic [SEG_WIDTH-1:0] SEG_MAX = 7'(MAX_SEGMENTS);
   localparam logic [SEG_WIDTH-1:0] SEG_RESET = 7'd8;

   localparam logic [2:0] CMD_MOVE  = 3'd0;
   localparam logic [2:0] CMD_LINE  = 3'd1;
   localparam logic [2:0] CMD_CONIC = 3'd2;
   localparam logic [2:0] CMD_CUBIC = 3'd3;
   localparam logic [2:0] CMD_CLOSE = 3'd4;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLOSE = 9'b000000010,
      S_MOVE  = 9'b000000100,
      S_LINE  = 9'b000001000,
      S_DIV   = 9'b000010000,
      S_STEP  = 9'b000100000,
      S_CALC  = 9'b001000000,
      S_DRAIN = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   // Where the registered product goes in the following cycle.
   typedef enum logic [3:0] {
      DST_NONE = 4'd0,
      DST_UT   = 4'd1,
      DST_UU   = 4'd2,
      DST_TT   = 4'd3,
      DST_W0   = 4'd4,
      DST_W1   = 4'd5,
      DST_W2   = 4'd6,
      DST_W3   = 4'd7,
      DST_XLO  = 4'd8,
      DST_XHI  = 4'd9,
      DST_YLO  = 4'd10,
      DST_YHI  = 4'd11
   } dst_type;

endpackage

[design/outline_bezier_flattener.sv]
// Outline command to polygon vertex converter with uniform-t curve flattening.
// Depends on obf_pkg (types, command codes, widths).
//
//  channel  ports                    direction  handshake
//  req      req_cmd, req_ctrl*, end  in         req_valid / req_ready
//  rsp      rsp_pt_*, flags, last    out        rsp_valid / rsp_ready
//  csr      csr_wr_en, csr_wr_data   in         write enable, no wait
//
// Line, close and a plain move pass through one output state; a move that closes
// a contour passes through the close state and then the move state. A curve runs
// a shift-subtract division for the t step, then computes each point (conic or
// cubic) on the one shared 34x25 multiplier.
// Reset is synchronous; it clears the contour state and sets 8 segments.
// A stalled rsp holds the sequencer; req_ready is high only while idle.
module outline_bezier_flattener (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic signed [31:0] req_ctrl1_x,
   input  logic signed [31:0] req_ctrl1_y,
   input  logic signed [31:0] req_ctrl2_x,
   input  logic signed [31:0] req_ctrl2_y,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_pt_x,
   output logic signed [31:0] rsp_pt_y,
   output logic        rsp_has_point,
   output logic        rsp_contour_start,
   output logic        rsp_contour_end,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   obf_pkg::state_type state_ff, state_in;

   logic [obf_pkg::SEG_WIDTH-1:0] seg_ff;
   logic signed [31:0] start_x_ff, start_y_ff, cur_x_ff, cur_y_ff;
   logic               open_ff;

   logic [2:0]         cmd_ff;
   logic signed [31:0] p0x_ff, p0y_ff, c1x_ff, c1y_ff, c2x_ff, c2y_ff, ex_ff, ey_ff;
   logic               cubic_ff;

   // t step generation
   logic [obf_pkg::SEG_WIDTH-1:0] n_ff, s_ff;
   logic [4:0]                    dcnt_ff;
   logic [7:0]                    drem_ff;
   logic [obf_pkg::T_WIDTH-1:0]   dq_ff, q_ff;
   logic [7:0]                    r_ff;

   // shared multiplier and its operands
   logic [4:0]                      op_ff;
   logic signed [obf_pkg::MA_WIDTH-1:0]   mul_a;
   logic [obf_pkg::MB_WIDTH-1:0]          mul_b;
   obf_pkg::dst_type                      mul_dst, dst_ff;
   logic signed [obf_pkg::PROD_WIDTH-1:0] prod_ff;
   logic [obf_pkg::SQ_WIDTH-1:0]  ut_ff, uu_ff, tt_ff;
   logic [obf_pkg::WGT_WIDTH-1:0] w_ff [4];
   logic signed [obf_pkg::ACC_WIDTH-1:0] acc_x_ff, acc_y_ff;

   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_x_ff, rsp_y_ff;
   logic                 rsp_hp_ff, rsp_cs_ff, rsp_ce_ff, rsp_last_ff;

   logic                 accept, out_free, last_op, differs, rsp_load;
   logic [obf_pkg::T_WIDTH-1:0] u_val;
   logic [obf_pkg::SEG_WIDTH-1:0] n_clamp;
   logic [4:0]           nw, cnt2, bidx, jidx, nops;
   logic [1:0]           term;
   logic                 ycoord;
   logic [obf_pkg::WGT_WIDTH-1:0] wsel;
   logic signed [31:0]   csel;
   logic [7:0]           drem_sh, r_sum;
   logic signed [obf_pkg::ACC_WIDTH-1:0] prod_ext, rnd_x, rnd_y;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == obf_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign u_val     = obf_pkg::T_ONE - q_ff;
   assign differs   = (cur_x_ff != start_x_ff) || (cur_y_ff != start_y_ff);
   assign rsp_load  = out_free && (state_ff inside {obf_pkg::S_CLOSE, obf_pkg::S_MOVE,
                                                    obf_pkg::S_LINE, obf_pkg::S_EMIT});

   always_comb begin
      if (seg_ff == '0) begin
         n_clamp = 7'd1;
      end else if (seg_ff > obf_pkg::SEG_MAX) begin
         n_clamp = obf_pkg::SEG_MAX;
      end else begin
         n_clamp = seg_ff;
      end
   end

   assign drem_sh = {drem_ff[6:0], (dcnt_ff == 5'd16)};
   assign r_sum   = r_ff + drem_ff;

   // Op schedule: weight products first, then x terms, then y terms (lo, hi per term).
   always_comb begin
      nw     = cubic_ff ? 5'd7 : 5'd3;
      cnt2   = cubic_ff ? 5'd8 : 5'd6;
      nops   = nw + cnt2 + cnt2;
      last_op = (op_ff == nops - 5'd1);
      bidx   = op_ff - nw;
      ycoord = (bidx >= cnt2);
      jidx   = ycoord ? (bidx - cnt2) : bidx;
      term   = jidx[2:1];
      if (cubic_ff) begin
         wsel = w_ff[term];
      end else begin
         case (term)
            2'd0:    wsel = {uu_ff, 16'b0};
            2'd1:    wsel = {ut_ff[31:0], 17'b0};
            default: wsel = {tt_ff, 16'b0};
         endcase
      end
      case (term)
         2'd0:    csel = ycoord ? p0y_ff : p0x_ff;
         2'd1:    csel = ycoord ? c1y_ff : c1x_ff;
         2'd2:    csel = cubic_ff ? (ycoord ? c2y_ff : c2x_ff) : (ycoord ? ey_ff : ex_ff);
         default: csel = ycoord ? ey_ff : ex_ff;
      endcase
      mul_a   = '0;
      mul_b   = '0;
      mul_dst = obf_pkg::DST_NONE;
      if (state_ff == obf_pkg::S_CALC) begin
         if (op_ff < nw) begin
            case (op_ff)
               5'd0: begin
                  mul_a = 34'(u_val); mul_b = 25'(q_ff); mul_dst = obf_pkg::DST_UT;
               end
               5'd1: begin
                  mul_a = 34'(u_val); mul_b = 25'(u_val); mul_dst = obf_pkg::DST_UU;
               end
               5'd2: begin
                  mul_a = 34'(q_ff); mul_b = 25'(q_ff); mul_dst = obf_pkg::DST_TT;
               end
               5'd3: begin
                  mul_a = 34'(uu_ff); mul_b = 25'(u_val); mul_dst = obf_pkg::DST_W0;
               end
               5'd4: begin
                  mul_a = 34'(uu_ff); mul_b = 25'(q_ff); mul_dst = obf_pkg::DST_W1;
               end
               5'd5: begin
                  mul_a = 34'(tt_ff); mul_b = 25'(u_val); mul_dst = obf_pkg::DST_W2;
               end
               default: begin
                  mul_a = 34'(tt_ff); mul_b = 25'(q_ff); mul_dst = obf_pkg::DST_W3;
               end
            endcase
         end else begin
            mul_a = 34'(csel);
            if (jidx[0]) begin
               mul_b   = 25'(wsel[obf_pkg::WGT_WIDTH-1:obf_pkg::WLO_WIDTH]);
               mul_dst = ycoord ? obf_pkg::DST_YHI : obf_pkg::DST_XHI;
            end else begin
               mul_b   = wsel[obf_pkg::WLO_WIDTH-1:0];
               mul_dst = ycoord ? obf_pkg::DST_YLO : obf_pkg::DST_XLO;
            end
         end
      end
   end

   assign prod_ext = 82'(prod_ff);
   assign rnd_x    = acc_x_ff + (82'sd1 <<< 47);
   assign rnd_y    = acc_y_ff + (82'sd1 <<< 47);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         obf_pkg::S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  obf_pkg::CMD_MOVE:  state_in = open_ff ? obf_pkg::S_CLOSE : obf_pkg::S_MOVE;
                  obf_pkg::CMD_LINE:  state_in = obf_pkg::S_LINE;
                  obf_pkg::CMD_CONIC,
                  obf_pkg::CMD_CUBIC: state_in = open_ff ? obf_pkg::S_DIV : obf_pkg::S_IDLE;
                  obf_pkg::CMD_CLOSE: state_in = open_ff ? obf_pkg::S_CLOSE : obf_pkg::S_IDLE;
                  default:            state_in = obf_pkg::S_IDLE;
               endcase
            end
         end
         obf_pkg::S_CLOSE: begin
            if (out_free) begin
               state_in = (cmd_ff == obf_pkg::CMD_MOVE) ? obf_pkg::S_MOVE : obf_pkg::S_IDLE;
            end
         end
         obf_pkg::S_MOVE, obf_pkg::S_LINE: begin
            if (out_free) begin
               state_in = obf_pkg::S_IDLE;
            end
         end
         obf_pkg::S_DIV: begin
            if (dcnt_ff == '0) begin
               state_in = obf_pkg::S_STEP;
            end
         end
         obf_pkg::S_STEP:  state_in = obf_pkg::S_CALC;
         obf_pkg::S_CALC: begin
            if (last_op) begin
               state_in = obf_pkg::S_DRAIN;
            end
         end
         obf_pkg::S_DRAIN: state_in = obf_pkg::S_EMIT;
         obf_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = (s_ff == n_ff) ? obf_pkg::S_IDLE : obf_pkg::S_STEP;
            end
         end
         default: state_in = obf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obf_pkg::S_IDLE;
         seg_ff       <= obf_pkg::SEG_RESET;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dst_ff       <= obf_pkg::DST_NONE;
      end else begin
         state_ff <= state_in;
         dst_ff   <= mul_dst;
         if (csr_wr_en) begin
            seg_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            obf_pkg::S_CLOSE: begin
               if (out_free) begin
                  cur_x_ff     <= start_x_ff;
                  cur_y_ff     <= start_y_ff;
                  open_ff      <= 1'b0;
               end
            end
            obf_pkg::S_MOVE: begin
               if (out_free) begin
                  start_x_ff   <= ex_ff;
                  start_y_ff   <= ey_ff;
                  cur_x_ff     <= ex_ff;
                  cur_y_ff     <= ey_ff;
                  open_ff      <= 1'b1;
               end
            end
            obf_pkg::S_LINE: begin
               if (out_free) begin
                  if (!open_ff) begin
                     start_x_ff <= ex_ff;
                     start_y_ff <= ey_ff;
                  end
                  cur_x_ff <= ex_ff;
                  cur_y_ff <= ey_ff;
                  open_ff  <= 1'b1;
               end
            end
            obf_pkg::S_EMIT: begin
               if (out_free) begin
                  cur_x_ff     <= rnd_x[79:48];
                  cur_y_ff     <= rnd_y[79:48];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * $signed({1'b0, mul_b});
      if (accept) begin
         cmd_ff   <= req_cmd;
         cubic_ff <= (req_cmd == obf_pkg::CMD_CUBIC);
         p0x_ff   <= cur_x_ff;
         p0y_ff   <= cur_y_ff;
         c1x_ff   <= req_ctrl1_x;
         c1y_ff   <= req_ctrl1_y;
         c2x_ff   <= req_ctrl2_x;
         c2y_ff   <= req_ctrl2_y;
         ex_ff    <= req_end_x;
         ey_ff    <= req_end_y;
         n_ff     <= n_clamp;
         s_ff     <= 7'd1;
         dcnt_ff  <= 5'd16;
         drem_ff  <= '0;
         dq_ff    <= '0;
         q_ff     <= '0;
         r_ff     <= {2'b0, n_clamp[6:1]};
      end
      // Restoring division of 2^16 by n: one quotient bit per cycle.
      if (state_ff == obf_pkg::S_DIV) begin
         if (drem_sh >= {1'b0, n_ff}) begin
            drem_ff <= drem_sh - {1'b0, n_ff};
            dq_ff   <= {dq_ff[15:0], 1'b1};
         end else begin
            drem_ff <= drem_sh;
            dq_ff   <= {dq_ff[15:0], 1'b0};
         end
         if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 5'd1;
         end
      end
      // Advance t by n-th of one, carrying the remainder.
      if (state_ff == obf_pkg::S_STEP) begin
         op_ff    <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         if (r_sum >= {1'b0, n_ff}) begin
            r_ff <= r_sum - {1'b0, n_ff};
            q_ff <= q_ff + dq_ff + 17'd1;
         end else begin
            r_ff <= r_sum;
            q_ff <= q_ff + dq_ff;
         end
      end
      if (state_ff == obf_pkg::S_CALC) begin
         op_ff <= op_ff + 5'd1;
      end
      case (dst_ff)
         obf_pkg::DST_UT:  ut_ff <= prod_ff[obf_pkg::SQ_WIDTH-1:0];
         obf_pkg::DST_UU:  uu_ff <= prod_ff[obf_pkg::SQ_WIDTH-1:0];
         obf_pkg::DST_TT:  tt_ff <= prod_ff[obf_pkg::SQ_WIDTH-1:0];
         obf_pkg::DST_W0:  w_ff[0] <= prod_ff[obf_pkg::WGT_WIDTH-1:0];
         obf_pkg::DST_W1:  w_ff[1] <= prod_ff[obf_pkg::WGT_WIDTH-1:0]
                                      + {prod_ff[obf_pkg::WGT_WIDTH-2:0], 1'b0};
         obf_pkg::DST_W2:  w_ff[2] <= prod_ff[obf_pkg::WGT_WIDTH-1:0]
                                      + {prod_ff[obf_pkg::WGT_WIDTH-2:0], 1'b0};
         obf_pkg::DST_W3:  w_ff[3] <= prod_ff[obf_pkg::WGT_WIDTH-1:0];
         obf_pkg::DST_XLO: acc_x_ff <= acc_x_ff + prod_ext;
         obf_pkg::DST_XHI: acc_x_ff <= acc_x_ff + (prod_ext <<< obf_pkg::WLO_WIDTH);
         obf_pkg::DST_YLO: acc_y_ff <= acc_y_ff + prod_ext;
         obf_pkg::DST_YHI: acc_y_ff <= acc_y_ff + (prod_ext <<< obf_pkg::WLO_WIDTH);
         default: begin
         end
      endcase
      if (out_free) begin
         case (state_ff)
            obf_pkg::S_CLOSE: begin
               rsp_x_ff    <= differs ? start_x_ff : '0;
               rsp_y_ff    <= differs ? start_y_ff : '0;
               rsp_hp_ff   <= differs;
               rsp_cs_ff   <= 1'b0;
               rsp_ce_ff   <= 1'b1;
               rsp_last_ff <= (cmd_ff != obf_pkg::CMD_MOVE);
            end
            obf_pkg::S_MOVE, obf_pkg::S_LINE: begin
               rsp_x_ff    <= ex_ff;
               rsp_y_ff    <= ey_ff;
               rsp_hp_ff   <= 1'b1;
               rsp_cs_ff   <= (state_ff == obf_pkg::S_MOVE) || !open_ff;
               rsp_ce_ff   <= 1'b0;
               rsp_last_ff <= 1'b1;
            end
            obf_pkg::S_EMIT: begin
               rsp_x_ff    <= rnd_x[79:48];
               rsp_y_ff    <= rnd_y[79:48];
               rsp_hp_ff   <= 1'b1;
               rsp_cs_ff   <= 1'b0;
               rsp_ce_ff   <= 1'b0;
               rsp_last_ff <= (s_ff == n_ff);
               s_ff        <= s_ff + 7'd1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pt_x          = rsp_x_ff;
   assign rsp_pt_y          = rsp_y_ff;
   assign rsp_has_point     = rsp_hp_ff;
   assign rsp_contour_start = rsp_cs_ff;
   assign rsp_contour_end   = rsp_ce_ff;
   assign rsp_last          = rsp_last_ff;

   // The final point of a curve sits exactly at t = 1.
   a_last_t_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == obf_pkg::S_EMIT && s_ff == n_ff) |-> (q_ff == obf_pkg::T_ONE))
      else $error("t did not reach one on final curve point");

   // The rounding remainder of the t step stays below the segment count.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == obf_pkg::S_CALC) |-> (r_ff < {1'b0, n_ff}))
      else $error("t step remainder out of range");

   // A contour only closes from the close sequence.
   a_close_path: assert property (@(posedge clock) disable iff (reset)
      $fell(open_ff) |-> ($past(state_ff) == obf_pkg::S_CLOSE))
      else $error("contour closed outside close sequence");

   // A close marker never starts a contour.
   a_marker_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_cs_ff && rsp_ce_ff))
      else $error("result marks both contour start and end");

endmodule

[verif/outline_bezier_flattener_tb.sv]
// Self-checking testbench for outline_bezier_flattener: outline commands in, vertices out.
// Predicts every vertex and contour marker in SystemVerilog and compares field by field.
// Depends on obf_pkg and the outline_bezier_flattener RTL.
module outline_bezier_flattener_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [31:0] c1x, c1y, c2x, c2y, ex, ey;
   } outline_cmd_type;

   typedef struct {
      logic signed [31:0] pt_x, pt_y;
      logic has_point, contour_start, contour_end, last;
   } vertex_type;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 200;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_cmd = '0;
   logic signed [31:0] req_ctrl1_x = '0, req_ctrl1_y = '0, req_ctrl2_x = '0, req_ctrl2_y = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_pt_x, rsp_pt_y;
   logic rsp_has_point, rsp_contour_start, rsp_contour_end, rsp_last;
   logic csr_wr_en = 0;
   logic [6:0] csr_wr_data = '0;

   outline_bezier_flattener dut (.*);

   outline_cmd_type pending_cmds[$];
   vertex_type      expected_vertices[$];
   int              error_count = 0;
   int              cycle_count = 0;

   // shadow contour state
   logic [6:0]         seg_count;
   logic signed [31:0] start_x, start_y, cur_x, cur_y;
   logic               contour_open;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] bernstein_sum(logic [63:0] w[4],
                                                        logic signed [31:0] c[4], int cnt);
      logic signed [95:0] acc, ww, cc;
      acc = '0;
      for (int i = 0; i < cnt; i++) begin
         ww = {32'b0, w[i]};
         cc = c[i];
         acc += ww * cc;
      end
      acc = (acc + (96'sd1 <<< 47)) >>> 48;
      return acc[31:0];
   endfunction

   task automatic push_vertex(logic signed [31:0] x, logic signed [31:0] y,
                              logic hp, logic cs, logic ce);
      vertex_type v;
      v.pt_x = x; v.pt_y = y; v.has_point = hp;
      v.contour_start = cs; v.contour_end = ce; v.last = 0;
      expected_vertices.insert(expected_vertices.size(), v);
   endtask

   task automatic close_contour();
      if (cur_x != start_x || cur_y != start_y) push_vertex(start_x, start_y, 1, 0, 1);
      else push_vertex(0, 0, 0, 0, 1);
      cur_x = start_x;
      cur_y = start_y;
      contour_open = 0;
   endtask

   task automatic flatten_command(outline_cmd_type c);
      int n_before;
      logic [63:0] n, t, u;
      logic [63:0] w[4];
      logic signed [31:0] px[4], py[4];
      logic signed [31:0] x, y;
      int cnt;
      n_before = expected_vertices.size();
      case (c.cmd)
         obf_pkg::CMD_MOVE: begin
            if (contour_open) close_contour();
            start_x = c.ex; start_y = c.ey;
            cur_x = c.ex; cur_y = c.ey;
            contour_open = 1;
            push_vertex(c.ex, c.ey, 1, 1, 0);
         end
         obf_pkg::CMD_LINE: begin
            push_vertex(c.ex, c.ey, 1, !contour_open, 0);
            if (!contour_open) begin
               start_x = c.ex; start_y = c.ey;
               contour_open = 1;
            end
            cur_x = c.ex; cur_y = c.ey;
         end
         obf_pkg::CMD_CONIC, obf_pkg::CMD_CUBIC: begin
            if (contour_open) begin
               n = seg_count;
               if (n < 1) n = 1;
               if (n > obf_pkg::MAX_SEGMENTS) n = obf_pkg::MAX_SEGMENTS;
               px = '{cur_x, c.c1x, c.c2x, c.ex};
               py = '{cur_y, c.c1y, c.c2y, c.ey};
               if (c.cmd == obf_pkg::CMD_CONIC) begin
                  px[2] = c.ex; py[2] = c.ey;
               end
               for (logic [63:0] s = 1; s <= n; s++) begin
                  t = (s * 65536 + n / 2) / n;
                  u = 65536 - t;
                  if (c.cmd == obf_pkg::CMD_CONIC) begin
                     w[0] = (u * u) << 16;
                     w[1] = (2 * u * t) << 16;
                     w[2] = (t * t) << 16;
                     w[3] = 0;
                     cnt = 3;
                  end else begin
                     w[0] = u * u * u;
                     w[1] = 3 * u * u * t;
                     w[2] = 3 * u * t * t;
                     w[3] = t * t * t;
                     cnt = 4;
                  end
                  x = bernstein_sum(w, px, cnt);
                  y = bernstein_sum(w, py, cnt);
                  push_vertex(x, y, 1, 0, 0);
                  cur_x = x; cur_y = y;
               end
            end
         end
         obf_pkg::CMD_CLOSE: if (contour_open) close_contour();
         default: ;
      endcase
      if (expected_vertices.size() > n_before)
         expected_vertices[expected_vertices.size() - 1].last = 1;
   endtask

   // driver: bursts of transactions separated by random gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(posedge clock) begin
      outline_cmd_type c;
      logic accepted;
      accepted = req_valid && req_ready;
      if (reset) begin
         seg_count <= obf_pkg::SEG_RESET;
         start_x = 0; start_y = 0; cur_x = 0; cur_y = 0;
         contour_open = 0;
      end else begin
         if (csr_wr_en) seg_count <= csr_wr_data;
         if (accepted) begin
            c.cmd = req_cmd;
            c.c1x = req_ctrl1_x; c.c1y = req_ctrl1_y;
            c.c2x = req_ctrl2_x; c.c2y = req_ctrl2_y;
            c.ex = req_end_x; c.ey = req_end_y;
            flatten_command(c);
         end
         if (!req_valid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_cmd <= c.cmd;
               req_ctrl1_x <= c.c1x; req_ctrl1_y <= c.c1y;
               req_ctrl2_x <= c.c2x; req_ctrl2_y <= c.c2y;
               req_end_x <= c.ex; req_end_y <= c.ey;
               req_valid <= 1;
               if (--burst_left <= 0) begin
                  burst_left = $urandom_range(1, 10);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor: receiver stalls follow a mode that is redrawn at random
   int stall_mode = 0;
   always @(posedge clock) begin
      vertex_type e;
      cycle_count++;
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $error("unexpected transaction: pt_x %0d pt_y %0d", rsp_pt_x, rsp_pt_y);
               error_count++;
            end else begin
               e = expected_vertices.pop_front();
               if (rsp_pt_x !== e.pt_x) begin
                  $error("pt_x expected %0d actual %0d", e.pt_x, rsp_pt_x); error_count++;
               end
               if (rsp_pt_y !== e.pt_y) begin
                  $error("pt_y expected %0d actual %0d", e.pt_y, rsp_pt_y); error_count++;
               end
               if (rsp_has_point !== e.has_point) begin
                  $error("has_point expected %0d actual %0d", e.has_point, rsp_has_point);
                  error_count++;
               end
               if (rsp_contour_start !== e.contour_start) begin
                  $error("contour_start expected %0d actual %0d", e.contour_start,
                         rsp_contour_start);
                  error_count++;
               end
               if (rsp_contour_end !== e.contour_end) begin
                  $error("contour_end expected %0d actual %0d", e.contour_end,
                         rsp_contour_end);
                  error_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_last); error_count++;
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return ($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 8000)) - 4000;
      endcase
   endfunction

   task automatic queue_cmd(logic [2:0] cmd, logic signed [31:0] c1x, logic signed [31:0] c1y,
                            logic signed [31:0] c2x, logic signed [31:0] c2y,
                            logic signed [31:0] ex, logic signed [31:0] ey);
      outline_cmd_type c;
      c.cmd = cmd; c.c1x = c1x; c.c1y = c1y; c.c2x = c2x; c.c2y = c2y; c.ex = ex; c.ey = ey;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic queue_rand(logic [2:0] cmd);
      queue_cmd(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
   endtask

   // mostly well-formed contours with random content, some noise
   task automatic queue_random_outlines(int count);
      int queued;
      logic signed [31:0] sx, sy;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_rand(3'($urandom_range(0, 7)));
            queued++;
         end else begin
            sx = rand_coord(); sy = rand_coord();
            queue_cmd(obf_pkg::CMD_MOVE, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), sx, sy);
            queued++;
            repeat ($urandom_range(1, 4)) begin
               queue_rand(3'($urandom_range(obf_pkg::CMD_LINE, obf_pkg::CMD_CUBIC)));
               queued++;
            end
            if ($urandom_range(0, 2) == 0) begin
               queue_cmd(obf_pkg::CMD_LINE, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), sx, sy);
               queued++;
            end
            if ($urandom_range(0, 3) != 0) begin
               queue_rand(obf_pkg::CMD_CLOSE);
               queued++;
            end
         end
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_cmds.size() > 0 || req_valid || expected_vertices.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_segments(logic [6:0] value);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      logic [6:0] seg_plan[7] = '{7'd1, 7'd3, 7'd64, 7'd0, 7'd127, 7'd5, 7'd2};
      int item_plan[7] = '{30, 28, 10, 20, 8, 30, 28};
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: extremes, every command and the corner cases, reset segment count
      queue_cmd(obf_pkg::CMD_CONIC, 1, 2, 3, 4, 5, 6);              // curve with no contour
      queue_cmd(obf_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0);              // close with no contour
      queue_cmd(obf_pkg::CMD_LINE, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000); // starts contour
      queue_cmd(obf_pkg::CMD_LINE, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
      queue_cmd(obf_pkg::CMD_CONIC, 32'sh80000000, 32'sh7fffffff, 0, 0, 32'sh7fffffff,
                32'sh80000000);
      queue_cmd(obf_pkg::CMD_CUBIC, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                32'sh7fffffff, -1, -1);
      queue_cmd(obf_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0);              // close with vertex
      queue_cmd(obf_pkg::CMD_MOVE, 0, 0, 0, 0, 100, -100);
      queue_cmd(obf_pkg::CMD_LINE, 0, 0, 0, 0, 640, 64);
      queue_cmd(obf_pkg::CMD_LINE, 0, 0, 0, 0, 100, -100);          // back to start
      queue_cmd(obf_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0);              // close without vertex
      queue_cmd(obf_pkg::CMD_MOVE, 0, 0, 0, 0, 7, 9);
      queue_cmd(obf_pkg::CMD_CUBIC, 0, 0, 0, 0, 0, 0);
      queue_cmd(obf_pkg::CMD_MOVE, 0, 0, 0, 0, -5, 3);              // move closes contour
      queue_cmd(3'd5, -1, -1, -1, -1, -1, -1);                      // unknown commands
      queue_cmd(3'd6, 32'sh55555555, 32'shaaaaaaaa, 1, 2, 3, 4);
      queue_cmd(3'd7, 32'shaaaaaaaa, 32'sh55555555, 4, 3, 2, 1);
      queue_cmd(obf_pkg::CMD_CONIC, 64, 64, 0, 0, 128, 0);
      queue_cmd(obf_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0);
      wait_idle();

      foreach (seg_plan[i]) begin
         write_segments(seg_plan[i]);
         queue_random_outlines(item_plan[i]);
         wait_idle();
      end
      write_segments(7'($urandom_range(1, 20)));
      queue_random_outlines(15);
      wait_idle();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
design/obf_pkg.sv
design/outline_bezier_flattener.sv
verif/outline_bezier_flattener_tb.sv
